// File: src/abps_pkg.sv
// Shared types, constants and the pattern table of the alert beep sequencer.
`timescale 1ns / 1ps

package abps_pkg;

    // Counter widths
    localparam int ELAPSED_BITS = 16;
    localparam int SILENCE_BITS = 24;

    // Field widths of the channels
    localparam int OP_W      = 2;
    localparam int KIND_W    = 3;
    localparam int SIL_MS_W  = 24;
    localparam int INDEX_W   = 3;
    localparam int GROUP_W   = 5;
    localparam int TIME_W    = 16;

    // Saturation limit of the group counter
    localparam logic [GROUP_W-1:0] GROUP_MAX = {GROUP_W{1'b1}};

    // Operation codes of an input word
    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_SILENCE = 2'd3
    } op_t;

    // One input word
    typedef struct packed {
        op_t                 op;
        logic [KIND_W-1:0]   alert_kind;
        logic [SIL_MS_W-1:0] silence_ms;
    } item_t;

    // One result word
    typedef struct packed {
        logic                beep_on;
        logic                alert_active;
        logic [KIND_W-1:0]   active_kind;
        logic                is_silenced;
        logic [SIL_MS_W-1:0] silence_left_ms;
        logic                request_taken;
    } result_t;

    // Timing of one alert kind
    typedef struct packed {
        logic [TIME_W-1:0]  beep;
        logic [TIME_W-1:0]  gap;
        logic [INDEX_W-1:0] per_group;
        logic [TIME_W-1:0]  pause;
        logic [GROUP_W-1:0] max_groups;
    } pattern_t;

    // Built-in pattern per kind; max_groups of zero means no limit
    function automatic pattern_t pattern_lookup(input logic [KIND_W-1:0] kind);
        pattern_t p;
        case (kind)
            3'd0:    p = '{16'd1000, 16'd500,  3'd3, 16'd10000, 5'd30};
            3'd1:    p = '{16'd200,  16'd300,  3'd2, 16'd5000,  5'd20};
            3'd2:    p = '{16'd200,  16'd0,    3'd1, 16'd30000, 5'd0};
            3'd3:    p = '{16'd100,  16'd100,  3'd5, 16'd15000, 5'd10};
            3'd4:    p = '{16'd500,  16'd200,  3'd4, 16'd8000,  5'd15};
            3'd5:    p = '{16'd300,  16'd200,  3'd3, 16'd10000, 5'd20};
            3'd6:    p = '{16'd1000, 16'd1000, 3'd2, 16'd12000, 5'd25};
            default: p = '{16'd500,  16'd0,    3'd1, 16'd0,     5'd1};
        endcase
        return p;
    endfunction

endpackage

// File: src/abps_in_reg.sv
// Input register of the alert beep sequencer: holds one accepted word.
`timescale 1ns / 1ps

module abps_in_reg
    import abps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [KIND_W-1:0]   s_alert_kind,
    input  logic [SIL_MS_W-1:0] s_silence_ms,
    input  logic                advance,
    output logic                item_valid,
    output item_t               item
);

    logic  valid_reg;
    item_t item_reg;

    // Take a new word when empty or when the held word moves on
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{op_t'(s_op), s_alert_kind, s_silence_ms};
        end
    end

endmodule

// File: src/abps_seq_core.sv
// Pattern state of the alert beep sequencer and its one-word update.
`timescale 1ns / 1ps

module abps_seq_core
    import abps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic                    enable_reg;
    logic                    running_reg,   running_next;
    logic [KIND_W-1:0]       kind_reg,      kind_next;
    logic                    sounding_reg,  sounding_next;
    logic [INDEX_W-1:0]      index_reg,     index_next;
    logic [GROUP_W-1:0]      group_reg,     group_next;
    logic                    after_reg,     after_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg,   elapsed_next;
    logic [SILENCE_BITS-1:0] silence_reg,   silence_next;
    logic                    taken;

    pattern_t                pat;
    logic [TIME_W-1:0]       wait_ms;
    logic [INDEX_W-1:0]      index_inc;
    logic [31:0]             sil_req;
    logic [31:0]             sil_sat;

    localparam logic [31:0] SIL_LIMIT = 32'((64'd1 << SILENCE_BITS) - 64'd1);

    assign pat       = pattern_lookup(kind_reg);
    assign wait_ms   = after_reg ? pat.pause : pat.gap;
    assign index_inc = index_reg + INDEX_W'(1);
    assign sil_req   = 32'(item.silence_ms);
    assign sil_sat   = (sil_req > SIL_LIMIT) ? SIL_LIMIT : sil_req;

    // Compute the state after one word
    always_comb begin
        running_next  = running_reg;
        kind_next     = kind_reg;
        sounding_next = sounding_reg;
        index_next    = index_reg;
        group_next    = group_reg;
        after_next    = after_reg;
        elapsed_next  = elapsed_reg;
        silence_next  = silence_reg;
        taken         = 1'b0;
        case (item.op)
            OP_TICK: begin
                if (silence_reg != '0) begin
                    silence_next = silence_reg - SILENCE_BITS'(1);
                end
                if (elapsed_reg != {ELAPSED_BITS{1'b1}}) begin
                    elapsed_next = elapsed_reg + ELAPSED_BITS'(1);
                end
                if (!enable_reg) begin
                    sounding_next = 1'b0;
                end else if (running_reg && silence_next == '0) begin
                    if (pat.max_groups != '0 && group_reg >= pat.max_groups) begin
                        // Group limit reached: stop the pattern
                        running_next  = 1'b0;
                        sounding_next = 1'b0;
                    end else if (!sounding_reg) begin
                        // Start the beep once the gap or group pause is over
                        if (32'(elapsed_next) >= 32'(wait_ms)) begin
                            sounding_next = 1'b1;
                            elapsed_next  = '0;
                            after_next    = 1'b0;
                        end
                    end else if (32'(elapsed_next) >= 32'(pat.beep)) begin
                        // End the beep and count a finished group
                        sounding_next = 1'b0;
                        elapsed_next  = '0;
                        index_next    = index_inc;
                        if (index_inc >= pat.per_group) begin
                            index_next = '0;
                            if (group_reg != GROUP_MAX) begin
                                group_next = group_reg + GROUP_W'(1);
                            end
                            if (pat.pause == '0) begin
                                running_next = 1'b0;
                            end else begin
                                after_next = 1'b1;
                            end
                        end
                    end
                end else begin
                    sounding_next = 1'b0;
                end
            end
            OP_TRIGGER: begin
                // Refuse while disabled or below the running priority
                if (enable_reg && !(running_reg && item.alert_kind > kind_reg)) begin
                    kind_next    = item.alert_kind;
                    running_next = 1'b1;
                    group_next   = '0;
                    index_next   = '0;
                    after_next   = 1'b0;
                    elapsed_next = '0;
                    taken        = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (running_reg && kind_reg == item.alert_kind) begin
                    running_next  = 1'b0;
                    group_next    = '0;
                    index_next    = '0;
                    after_next    = 1'b0;
                    elapsed_next  = '0;
                    sounding_next = 1'b0;
                    taken         = 1'b1;
                end
            end
            OP_SILENCE: begin
                if (running_reg) begin
                    silence_next  = SILENCE_BITS'(sil_sat);
                    sounding_next = 1'b0;
                    taken         = 1'b1;
                end
            end
            default: begin
                taken = 1'b0;
            end
        endcase
    end

    // Result as seen after the update
    assign result = '{
        beep_on:         sounding_next && enable_reg,
        alert_active:    running_next,
        active_kind:     kind_next,
        is_silenced:     silence_next != '0,
        silence_left_ms: SIL_MS_W'(32'(silence_next)),
        request_taken:   taken
    };

    // Hold pattern state; apply register writes and words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b1;
            running_reg  <= 1'b0;
            kind_reg     <= '0;
            sounding_reg <= 1'b0;
            index_reg    <= '0;
            group_reg    <= '0;
            after_reg    <= 1'b0;
            elapsed_reg  <= '0;
            silence_reg  <= '0;
        end else if (cfg_wr_en) begin
            enable_reg <= cfg_wr_data;
            if (!cfg_wr_data) begin
                sounding_reg <= 1'b0;
            end
        end else if (step) begin
            running_reg  <= running_next;
            kind_reg     <= kind_next;
            sounding_reg <= sounding_next;
            index_reg    <= index_next;
            group_reg    <= group_next;
            after_reg    <= after_next;
            elapsed_reg  <= elapsed_next;
            silence_reg  <= silence_next;
        end
    end

endmodule

// File: src/alert_beep_pattern_sequencer_core.sv
// Top level of the alert beep sequencer: input register, pattern core, output register.
`timescale 1ns / 1ps

// Alert beep sequencer for eight alert kinds.
// Input channel (s_valid/s_ready): one word per request. s_op selects a
// 1 ms tick, a trigger, a clear or a silence; s_alert_kind names the kind
// for trigger and clear; s_silence_ms gives the silence length.
// Result channel (m_valid/m_ready): one word per input word, in order,
// with the buzzer level, pattern status, silence countdown and whether the
// request took effect.
// cfg_wr_en/cfg_wr_data write buzzer_enable; write it only while idle.
// A word accepted into the input register is updated by the pattern core and
// held in the result register, which drives the result channel.
// Throughput: one word per cycle unless m_ready stalls; the whole update is
// a single pass of logic between the input register and the result register.
// The input register keeps taking words while the result register is free
// or is being read; when m_ready stays low both registers fill and s_ready
// drops until the result is taken.
// Reset (aresetn low, synchronous): no pattern running, no silence,
// buzzer enabled, both registers empty.
module alert_beep_pattern_sequencer_core
    import abps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [KIND_W-1:0]   s_alert_kind,
    input  logic [SIL_MS_W-1:0] s_silence_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_beep_on,
    output logic                m_alert_active,
    output logic [KIND_W-1:0]   m_active_kind,
    output logic                m_is_silenced,
    output logic [SIL_MS_W-1:0] m_silence_left_ms,
    output logic                m_request_taken
);

    logic    item_valid;
    item_t   item;
    logic    advance;
    result_t result;
    logic    m_valid_reg;
    result_t result_reg;

    // Move a word on when the result register is free or being read
    assign advance = item_valid && (!m_valid_reg || m_ready);

    abps_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_alert_kind (s_alert_kind),
        .s_silence_ms (s_silence_ms),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    abps_seq_core u_seq_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (item),
        .result      (result)
    );

    // Hold the result word until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_beep_on         = result_reg.beep_on;
    assign m_alert_active    = result_reg.alert_active;
    assign m_active_kind     = result_reg.active_kind;
    assign m_is_silenced     = result_reg.is_silenced;
    assign m_silence_left_ms = result_reg.silence_left_ms;
    assign m_request_taken   = result_reg.request_taken;

endmodule

// File: src/abps_checker.sv
// Port-level checks of the alert beep sequencer, bound to the top level.
`timescale 1ns / 1ps

module abps_checker
    import abps_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_beep_on,
    input logic                m_alert_active,
    input logic                m_is_silenced,
    input logic [SIL_MS_W-1:0] m_silence_left_ms
);

    // Drop the result word after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // Sound only while a pattern runs
    a_beep_needs_alert: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beep_on |-> m_alert_active)
        else $error("beep on with no alert running");

    // Keep the buzzer quiet during silence
    a_beep_not_silenced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beep_on |-> !m_is_silenced)
        else $error("beep on while silenced");

    // Flag silence exactly when time is left
    a_silence_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_silenced == (m_silence_left_ms != '0)))
        else $error("silence flag disagrees with remaining time");

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_silence_left_ms))
        else $error("stalled result word changed");

endmodule

bind alert_beep_pattern_sequencer_core abps_checker u_abps_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_beep_on         (m_beep_on),
    .m_alert_active    (m_alert_active),
    .m_is_silenced     (m_is_silenced),
    .m_silence_left_ms (m_silence_left_ms)
);
